[rtl/core/byte_head_tail_capture_defines.svh]
// Assertion macros shared by the byte head/tail capture RTL.
`ifndef BYTE_HEAD_TAIL_CAPTURE_DEFINES_SVH
`define BYTE_HEAD_TAIL_CAPTURE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BHTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhtc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BHTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhtc: next-cycle check failed");

`endif

[rtl/core/bhtc_pkg.sv]
// Shared types and constants of the byte head/tail capture block.
`timescale 1ns / 1ps
`default_nettype none

package bhtc_pkg;

  // Field widths
  localparam int OPC_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int TL_W   = 13;
  localparam int KIND_W = 2;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_DATA   = 2'd0;
  localparam logic [OPC_W-1:0] OP_FINISH = 2'd1;
  localparam logic [OPC_W-1:0] OP_FETCH  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LIMIT = 1'b1;
  localparam logic [CNT_W-1:0] HEAD_LIMIT_RESET = 32'd10;
  localparam logic [TL_W-1:0]  TAIL_LIMIT_RESET = 13'd10;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Remainder unit lanes
  localparam int MOD_LANES  = 3;
  localparam int LANE_WP    = 0;
  localparam int LANE_FILL  = 1;
  localparam int LANE_DRAIN = 2;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] out_byte;
    logic              omission;
    logic [CNT_W-1:0]  omitted_count;
    logic [TL_W-1:0]   tail_length;
    logic              add_newline;
    logic              last_tail;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  typedef struct packed {
    logic busy;
    logic pend;
  } core_stat_t;

endpackage

`default_nettype wire

[rtl/core/bhtc_if.sv]
// Input and result channel interfaces of the byte head/tail capture block.
`timescale 1ns / 1ps
`default_nettype none

interface bhtc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bhtc_pkg::OPC_W-1:0]   opcode;
  logic [bhtc_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, opcode, data_byte, input ready);
  modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface bhtc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bhtc_pkg::KIND_W-1:0]  result_kind;
  logic [bhtc_pkg::BYTE_W-1:0]  out_byte;
  logic                         omission;
  logic [bhtc_pkg::CNT_W-1:0]   omitted_count;
  logic [bhtc_pkg::TL_W-1:0]    tail_length;
  logic                         add_newline;
  logic                         last_tail;

  modport source (output valid, result_kind, out_byte, omission, omitted_count,
                  tail_length, add_newline, last_tail, input ready);
  modport sink   (input valid, result_kind, out_byte, omission, omitted_count,
                  tail_length, add_newline, last_tail, output ready);
endinterface

`default_nettype wire

[rtl/core/byte_head_tail_capture.sv]
// Byte head/tail capture: passes the head of a stream, keeps its tail in a ring.
//
// in_ch carries opcode and data_byte; a transfer happens when valid and ready
// are high at a rising edge. Data bytes within head_limit come back as head
// results; later bytes go into the tail ring and give no result. A finish
// gives one summary, each fetch gives one tail byte oldest first or "nothing
// left". A result passes through the registered result stage and then the
// result queue before it is valid on out_ch. One item is taken per cycle
// while ready is high; a data byte past the head does one ring write if the
// tail depth is nonzero; a finish or a tail-byte fetch one registered read.
// A four-entry result queue absorbs receiver stalls: in_ch keeps taking items
// while results wait and drops ready for want of space only when queue plus
// result stage hold four results. cfg_we writes head_limit (index 0) or
// tail_limit (index 1). A tail_limit write starts a bit-serial remainder
// pass over the ring positions and holds in_ch ready low until its residues
// are committed. Reset (rst_n low, synchronous) clears the stream counters
// and sets both limits to 10; the ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module byte_head_tail_capture #(
  parameter int TAIL_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bhtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bhtc_pkg::CFG_DATA_W-1:0] cfg_data,
  bhtc_in_if.sink                         in_ch,
  bhtc_out_if.source                      out_ch
);

  bhtc_pkg::core_stat_t              stat;
  bhtc_pkg::result_t                 push_data;
  logic                              push;
  logic [bhtc_pkg::FIFO_CW-1:0]      level;
  logic [bhtc_pkg::FIFO_CW:0]        pending;
  logic                              in_ready;
  logic                              in_fire;

  // Accept while the remainder unit is idle and a queue slot is free
  assign pending  = {1'b0, level} + (bhtc_pkg::FIFO_CW + 1)'(stat.pend);
  assign in_ready = !stat.busy && (pending < (bhtc_pkg::FIFO_CW + 1)'(bhtc_pkg::FIFO_DEPTH));
  assign in_ch.ready = in_ready;
  assign in_fire  = in_ch.valid && in_ready;

  bhtc_core #(
    .TAIL_DEPTH (TAIL_DEPTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_opcode    (in_ch.opcode),
    .in_data_byte (in_ch.data_byte),
    .stat         (stat),
    .push         (push),
    .push_data    (push_data)
  );

  bhtc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_ch    (out_ch),
    .level     (level)
  );

endmodule

`default_nettype wire

[rtl/core/bhtc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bhtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/bhtc_mod_unit.sv]
// Bit-serial remainder unit: reduces ring positions modulo the ring depth.
`timescale 1ns / 1ps
`default_nettype none

module bhtc_mod_unit #(
  parameter int NW = 13,
  parameter int MW = 13,
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MW-1:0]       modulus,
  input  logic [NW-1:0]       num [bhtc_pkg::MOD_LANES],
  output bhtc_pkg::mod_stat_t stat,
  output logic [AW-1:0]       res [bhtc_pkg::MOD_LANES]
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r [bhtc_pkg::MOD_LANES];
  logic [NW-1:0] num_nxt [bhtc_pkg::MOD_LANES];
  logic [MW-1:0] rem_r [bhtc_pkg::MOD_LANES];
  logic [MW-1:0] rem_nxt [bhtc_pkg::MOD_LANES];
  logic [MW:0]   step [bhtc_pkg::MOD_LANES];

  // Load on start, then shift one numerator bit into each remainder per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < bhtc_pkg::MOD_LANES; i++) begin
      step[i] = {rem_r[i], num_r[i][NW-1]};
      if (step[i] >= {1'b0, modulus}) begin
        step[i] = step[i] - {1'b0, modulus};
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      for (int i = 0; i < bhtc_pkg::MOD_LANES; i++) begin
        num_nxt[i] = num[i];
        rem_nxt[i] = '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < bhtc_pkg::MOD_LANES; i++) begin
        rem_nxt[i] = step[i][MW-1:0];
        num_nxt[i] = {num_r[i][NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    for (int i = 0; i < bhtc_pkg::MOD_LANES; i++) begin
      res[i] = rem_r[i][AW-1:0];
    end
  end

  // Busy covers the commit cycle so no item sees stale residues
  assign stat.busy = busy_r | done_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[rtl/core/bhtc_core.sv]
// Stream state, ring access and result stage of the byte head/tail capture.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_head_tail_capture_defines.svh"

module bhtc_core #(
  parameter int TAIL_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bhtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhtc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_fire,
  input  logic [bhtc_pkg::OPC_W-1:0]        in_opcode,
  input  logic [bhtc_pkg::BYTE_W-1:0]       in_data_byte,
  output bhtc_pkg::core_stat_t              stat,
  output logic                              push,
  output bhtc_pkg::result_t                 push_data
);

  localparam int AW = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam int MW = $clog2(TAIL_DEPTH + 1);
  localparam int EW = (MW > bhtc_pkg::TL_W) ? MW : bhtc_pkg::TL_W;
  localparam int NW = (AW > bhtc_pkg::TL_W) ? AW : bhtc_pkg::TL_W;
  localparam int TL = bhtc_pkg::TL_W;
  localparam int CN = bhtc_pkg::CNT_W;
  localparam int BW = bhtc_pkg::BYTE_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(TAIL_DEPTH);

  // Configuration and stream state
  logic [CN-1:0] head_limit_r, head_limit_nxt;
  logic [TL-1:0] tail_limit_r, tail_limit_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [TL-1:0] fill_r, fill_nxt;
  logic [CN-1:0] head_sent_r, head_sent_nxt;
  logic [CN-1:0] total_r, total_nxt;
  logic [BW-1:0] last_head_r, last_head_nxt;
  logic [TL-1:0] drain_r, drain_nxt;
  logic          finished_r, finished_nxt;
  // Residues of the raw positions modulo the ring modulus
  logic [AW-1:0] wpm_r, wpm_nxt;
  logic [AW-1:0] fillm_r, fillm_nxt;
  logic [AW-1:0] drainm_r, drainm_nxt;

  // Result stage
  logic                         b_valid_r, b_valid_nxt;
  logic [bhtc_pkg::KIND_W-1:0]  b_kind_r, b_kind_nxt;
  logic [BW-1:0]                b_byte_r, b_byte_nxt;
  logic                         b_use_ram_r, b_use_ram_nxt;
  logic                         b_omit_r, b_omit_nxt;
  logic [CN-1:0]                b_total_r, b_total_nxt;
  logic [CN:0]                  b_used_r, b_used_nxt;
  logic [TL-1:0]                b_tail_len_r, b_tail_len_nxt;
  logic                         b_nl_ram_r, b_nl_ram_nxt;
  logic                         b_nl_fixed_r, b_nl_fixed_nxt;
  logic                         b_last_r, b_last_nxt;

  logic [EW-1:0] eff_m;
  logic [EW-1:0] mod_m;
  logic          clear;
  logic [AW-1:0] wp_c, wpm_c, fillm_c;
  logic [TL-1:0] fill_c;
  logic [CN-1:0] head_c, total_c;
  logic [BW-1:0] last_c;
  logic [EW-1:0] wp_step, f_e, f1, f2;
  logic [AW-1:0] wp_new;
  logic          omit;
  logic [AW-1:0] back_sel, rd_addr;
  logic          ram_we, ram_re;
  logic [BW-1:0] ram_rdata;
  logic          mod_start;
  logic [NW-1:0] mod_num [bhtc_pkg::MOD_LANES];
  logic [AW-1:0] mod_res [bhtc_pkg::MOD_LANES];
  bhtc_pkg::mod_stat_t mstat;

  // Effective tail depth and ring modulus
  assign eff_m = (EW'(tail_limit_r) >= DEPTH_E) ? DEPTH_E : EW'(tail_limit_r);
  assign mod_m = (eff_m == '0) ? DEPTH_E : eff_m;

  // Values after the stream reset that a data byte after finish causes
  assign clear   = (in_opcode == bhtc_pkg::OP_DATA) && finished_r;
  assign wp_c    = clear ? '0 : wp_r;
  assign wpm_c   = clear ? '0 : wpm_r;
  assign fill_c  = clear ? '0 : fill_r;
  assign fillm_c = clear ? '0 : fillm_r;
  assign head_c  = clear ? '0 : head_sent_r;
  assign total_c = clear ? '0 : total_r;
  assign last_c  = clear ? bhtc_pkg::NEWLINE : last_head_r;

  // Ring read address: newest byte on finish, drain position on fetch
  assign back_sel = (in_opcode == bhtc_pkg::OP_FINISH)
                    ? ((mod_m == EW'(1)) ? AW'(0) : AW'(1))
                    : drainm_r;
  assign rd_addr  = (wpm_r >= back_sel)
                    ? AW'(wpm_r - back_sel)
                    : AW'(EW'(wpm_r) + mod_m - EW'(back_sel));

  // Summary omission check
  assign omit = {1'b0, total_r} > ({1'b0, head_limit_r} + (CN + 1)'(eff_m));

  // Stream update for one transfer
  always_comb begin
    head_limit_nxt = head_limit_r;
    tail_limit_nxt = tail_limit_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    head_sent_nxt  = head_sent_r;
    total_nxt      = total_r;
    last_head_nxt  = last_head_r;
    drain_nxt      = drain_r;
    finished_nxt   = finished_r;
    wpm_nxt        = wpm_r;
    fillm_nxt      = fillm_r;
    drainm_nxt     = drainm_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    wp_step        = EW'(wpm_c) + EW'(1);
    wp_new         = (wp_step >= eff_m) ? '0 : AW'(wp_step);
    f_e            = EW'(fill_c);
    f1             = (f_e > eff_m) ? eff_m : f_e;
    f2             = (f1 < eff_m) ? (f1 + EW'(1)) : f1;
    b_valid_nxt    = 1'b0;
    b_kind_nxt     = bhtc_pkg::KIND_EMPTY;
    b_byte_nxt     = '0;
    b_use_ram_nxt  = 1'b0;
    b_omit_nxt     = 1'b0;
    b_total_nxt    = '0;
    b_used_nxt     = '0;
    b_tail_len_nxt = '0;
    b_nl_ram_nxt   = 1'b0;
    b_nl_fixed_nxt = 1'b0;
    b_last_nxt     = 1'b0;

    if (in_fire) begin
      case (in_opcode)
        bhtc_pkg::OP_DATA: begin
          finished_nxt  = 1'b0;
          wp_nxt        = wp_c;
          wpm_nxt       = wpm_c;
          fill_nxt      = fill_c;
          fillm_nxt     = fillm_c;
          head_sent_nxt = head_c;
          last_head_nxt = last_c;
          if (clear) begin
            drain_nxt  = '0;
            drainm_nxt = '0;
          end
          total_nxt = (total_c == '1) ? total_c : (total_c + CN'(1));
          if (head_c < head_limit_r) begin
            // Pass through as a head byte
            head_sent_nxt = head_c + CN'(1);
            last_head_nxt = in_data_byte;
            b_valid_nxt   = 1'b1;
            b_kind_nxt    = bhtc_pkg::KIND_HEAD;
            b_byte_nxt    = in_data_byte;
          end else if (eff_m != '0) begin
            // Store into the ring, overwrite the oldest once full
            ram_we    = 1'b1;
            wp_nxt    = wp_new;
            wpm_nxt   = wp_new;
            fill_nxt  = TL'(f2);
            fillm_nxt = (f2 == eff_m) ? '0 : AW'(f2);
          end
        end
        bhtc_pkg::OP_FINISH: begin
          finished_nxt   = 1'b1;
          drain_nxt      = fill_r;
          drainm_nxt     = fillm_r;
          ram_re         = 1'b1;
          b_valid_nxt    = 1'b1;
          b_kind_nxt     = bhtc_pkg::KIND_SUMMARY;
          b_omit_nxt     = omit;
          b_total_nxt    = total_r;
          b_used_nxt     = {1'b0, head_sent_r} + (CN + 1)'(fill_r);
          b_tail_len_nxt = fill_r;
          b_nl_ram_nxt   = (fill_r != '0);
          b_nl_fixed_nxt = !omit && (last_head_r != bhtc_pkg::NEWLINE);
        end
        bhtc_pkg::OP_FETCH: begin
          b_valid_nxt = 1'b1;
          if (finished_r && (drain_r != '0)) begin
            ram_re        = 1'b1;
            b_kind_nxt    = bhtc_pkg::KIND_TAIL;
            b_use_ram_nxt = 1'b1;
            b_last_nxt    = (drain_r == TL'(1));
            drain_nxt     = drain_r - TL'(1);
            drainm_nxt    = (drainm_r == '0) ? AW'(mod_m - EW'(1)) : (drainm_r - AW'(1));
          end
        end
        default: begin
        end
      endcase
    end

    // Commit residues after a tail depth change
    if (mstat.done) begin
      wpm_nxt    = mod_res[bhtc_pkg::LANE_WP];
      fillm_nxt  = mod_res[bhtc_pkg::LANE_FILL];
      drainm_nxt = mod_res[bhtc_pkg::LANE_DRAIN];
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        bhtc_pkg::CFG_HEAD_LIMIT: head_limit_nxt = cfg_data;
        bhtc_pkg::CFG_TAIL_LIMIT: tail_limit_nxt = cfg_data[TL-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_limit_r <= bhtc_pkg::HEAD_LIMIT_RESET;
      tail_limit_r <= bhtc_pkg::TAIL_LIMIT_RESET;
      wp_r         <= '0;
      fill_r       <= '0;
      head_sent_r  <= '0;
      total_r      <= '0;
      last_head_r  <= bhtc_pkg::NEWLINE;
      drain_r      <= '0;
      finished_r   <= 1'b0;
      wpm_r        <= '0;
      fillm_r      <= '0;
      drainm_r     <= '0;
      b_valid_r    <= 1'b0;
    end else begin
      head_limit_r <= head_limit_nxt;
      tail_limit_r <= tail_limit_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      head_sent_r  <= head_sent_nxt;
      total_r      <= total_nxt;
      last_head_r  <= last_head_nxt;
      drain_r      <= drain_nxt;
      finished_r   <= finished_nxt;
      wpm_r        <= wpm_nxt;
      fillm_r      <= fillm_nxt;
      drainm_r     <= drainm_nxt;
      b_valid_r    <= b_valid_nxt;
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    b_kind_r     <= b_kind_nxt;
    b_byte_r     <= b_byte_nxt;
    b_use_ram_r  <= b_use_ram_nxt;
    b_omit_r     <= b_omit_nxt;
    b_total_r    <= b_total_nxt;
    b_used_r     <= b_used_nxt;
    b_tail_len_r <= b_tail_len_nxt;
    b_nl_ram_r   <= b_nl_ram_nxt;
    b_nl_fixed_r <= b_nl_fixed_nxt;
    b_last_r     <= b_last_nxt;
  end

  bhtc_ram #(
    .WIDTH (BW),
    .DEPTH (TAIL_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpm_c),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Reduce raw positions when the tail depth is rewritten
  assign mod_start = cfg_we && (cfg_index == bhtc_pkg::CFG_TAIL_LIMIT);
  assign mod_num[bhtc_pkg::LANE_WP]    = NW'(wp_r);
  assign mod_num[bhtc_pkg::LANE_FILL]  = NW'(fill_r);
  assign mod_num[bhtc_pkg::LANE_DRAIN] = NW'(drain_r);

  bhtc_mod_unit #(
    .NW (NW),
    .MW (MW),
    .AW (AW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .modulus (MW'(mod_m)),
    .num     (mod_num),
    .stat    (mstat),
    .res     (mod_res)
  );

  // Final result with ring data merged in
  always_comb begin
    push_data.result_kind   = b_kind_r;
    push_data.out_byte      = b_use_ram_r ? ram_rdata : b_byte_r;
    push_data.omission      = b_omit_r;
    push_data.omitted_count = (b_omit_r && ({1'b0, b_total_r} > b_used_r))
                              ? CN'({1'b0, b_total_r} - b_used_r) : '0;
    push_data.tail_length   = b_tail_len_r;
    push_data.add_newline   = b_nl_ram_r ? (ram_rdata != bhtc_pkg::NEWLINE) : b_nl_fixed_r;
    push_data.last_tail     = b_last_r;
  end

  assign push      = b_valid_r;
  assign stat.busy = mstat.busy;
  assign stat.pend = b_valid_r;

  `BHTC_ASSERT_NOW(a_drain_idle, clk, rst_n, !finished_r, drain_r == '0)
  `BHTC_ASSERT_NOW(a_wp_residue, clk, rst_n, !mstat.busy && (EW'(wp_r) < mod_m),
                   wpm_r == wp_r)
  `BHTC_ASSERT_NOW(a_no_fire_busy, clk, rst_n, in_fire, !mstat.busy)
  `BHTC_ASSERT_NEXT(a_start_busy, clk, rst_n, mod_start, mstat.busy)

endmodule

`default_nettype wire

[rtl/core/bhtc_out_fifo.sv]
// Four-entry result queue that drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_head_tail_capture_defines.svh"

module bhtc_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  bhtc_pkg::result_t               push_data,
  bhtc_out_if.source                      out_ch,
  output logic [bhtc_pkg::FIFO_CW-1:0]    level
);

  localparam int AW = bhtc_pkg::FIFO_AW;
  localparam int CW = bhtc_pkg::FIFO_CW;

  bhtc_pkg::result_t mem_r [bhtc_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  bhtc_pkg::result_t head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Drive the oldest entry
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.result_kind   = head.result_kind;
  assign out_ch.out_byte      = head.out_byte;
  assign out_ch.omission      = head.omission;
  assign out_ch.omitted_count = head.omitted_count;
  assign out_ch.tail_length   = head.tail_length;
  assign out_ch.add_newline   = head.add_newline;
  assign out_ch.last_tail     = head.last_tail;
  assign level                = count_r;

  `BHTC_ASSERT_NOW(a_no_overflow, clk, rst_n, push,
                   count_r != CW'(bhtc_pkg::FIFO_DEPTH))

endmodule

`default_nettype wire
